>>> rtl/core/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants for the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    // default line length in bytes
    localparam int LINE_DEPTH_DEF = 16;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // character codes
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_GT  = 8'h3e;
    localparam logic [7:0] CH_UP  = 8'h41;
    localparam logic [7:0] CH_DN  = 8'h42;
    localparam logic [7:0] CH_RT  = 8'h43;
    localparam logic [7:0] CH_LT  = 8'h44;
    localparam logic [7:0] CH_LB  = 8'h5b;
    localparam logic [7:0] CH_TIL = 8'h7e;
    localparam logic [7:0] CH_DEL = 8'h7f;

    // operations handed from front to back
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INS,
        OP_DEL,
        OP_NL,
        OP_RIGHT,
        OP_LEFT
    } t_op;

    typedef struct packed {
        logic       prompt;
        t_op        op;
        logic [7:0] data;
    } t_cmd;

endpackage

>>> rtl/core/tle_front.sv
// ----------------------------------------------------------------------------
// tle_front
// Accepts requests, tracks the escape sequence mode and turns each byte into
// an editing command for the back end.
// ----------------------------------------------------------------------------
module tle_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_q_full,
    output logic        o_in_stall,
    output logic        o_push,
    output tle_pkg::t_cmd o_cmd
);
    import tle_pkg::*;

    typedef enum logic [1:0] {
        M_DATA,
        M_ESC,
        M_CSI,
        M_DONE
    } t_mode;

    t_mode r_mode;
    t_mode n_mode;
    t_mode m_cur;
    t_op   op;
    logic  prompt;
    logic  accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // classify the request
    always_comb begin
        prompt = (r_mode == M_DONE);
        m_cur  = prompt ? M_DATA : r_mode;
        op     = OP_NOP;
        n_mode = m_cur;
        if (i_action) begin
            if (i_rx_byte == CH_ESC) begin
                n_mode = M_ESC;
            end else if (i_rx_byte == CH_DEL) begin
                op     = OP_DEL;
                n_mode = M_DATA;
            end else if (i_rx_byte == CH_CR || i_rx_byte == CH_LF) begin
                op     = OP_NL;
                n_mode = M_DONE;
            end else if (m_cur == M_ESC) begin
                if (i_rx_byte == CH_LB) begin
                    n_mode = M_CSI;
                end else if (i_rx_byte == CH_TIL) begin
                    n_mode = M_DATA;
                end
            end else if (m_cur == M_CSI) begin
                if (i_rx_byte == CH_UP || i_rx_byte == CH_DN || i_rx_byte == CH_TIL) begin
                    n_mode = M_DATA;
                end else if (i_rx_byte == CH_RT) begin
                    op     = OP_RIGHT;
                    n_mode = M_DATA;
                end else if (i_rx_byte == CH_LT) begin
                    op     = OP_LEFT;
                    n_mode = M_DATA;
                end
            end else begin
                op = OP_INS;
            end
        end
    end

    // commands with no operation and no prompt due cannot give a result and are not queued
    assign o_push      = accept && (prompt || op != OP_NOP);
    assign o_cmd.prompt = prompt;
    assign o_cmd.op     = op;
    assign o_cmd.data   = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_DONE;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

endmodule

>>> rtl/core/tle_queue.sv
// ----------------------------------------------------------------------------
// tle_queue
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module tle_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tle_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output tle_pkg::t_cmd o_cmd
);
    import tle_pkg::*;

    t_cmd                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_q[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/tle_back.sv
// ----------------------------------------------------------------------------
// tle_back
// Carries out editing commands on the line memory and sends the echo, line
// and end-marker results through a one-deep hold stage and output register.
// ----------------------------------------------------------------------------
module tle_back #(
    parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  tle_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_out_byte,
    output logic          o_last
);
    import tle_pkg::*;

    localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LINE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_PRM0, S_PRM1, S_DISP,
        S_IRD, S_IEM, S_BS,
        S_DBS, S_DRD, S_DEM, S_DSP, S_DBS2,
        S_RRD, S_REM, S_LFT,
        S_CR, S_LF, S_NRD, S_NEM, S_NEND,
        S_FIN
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [CNT_W-1:0]   r_cur;
    logic [CNT_W-1:0]   r_len;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_cnt;
    logic [7:0]         r_carry;
    logic [7:0]         r_rdata;
    logic [7:0]         r_line_mem [LINE_DEPTH];
    logic               r_pend_valid;
    logic [1:0]         r_pend_kind;
    logic [7:0]         r_pend_byte;
    logic               r_out_valid;
    logic [1:0]         r_kind;
    logic [7:0]         r_byte;
    logic               r_last;

    logic               emit_req;
    logic [1:0]         e_kind;
    logic [7:0]         e_byte;
    logic               fin;
    logic               out_free;
    logic               emit_ok;
    logic               do_emit;
    logic               fin_load;
    logic               mem_we;
    logic [7:0]         mem_wdata;
    logic [CNT_W-1:0]   rd_idx;

    // result produced in the current state
    always_comb begin
        emit_req = 1'b0;
        e_kind   = KIND_ECHO;
        e_byte   = '0;
        fin      = 1'b0;
        case (r_state)
            S_PRM0: begin
                emit_req = 1'b1;
                e_byte   = CH_GT;
            end
            S_PRM1, S_DSP: begin
                emit_req = 1'b1;
                e_byte   = CH_SP;
            end
            S_IEM: begin
                emit_req = 1'b1;
                e_byte   = r_carry;
            end
            S_BS: begin
                emit_req = (r_cnt != '0);
                e_byte   = CH_BS;
            end
            S_DBS, S_DBS2, S_LFT: begin
                emit_req = 1'b1;
                e_byte   = CH_BS;
            end
            S_DEM, S_REM: begin
                emit_req = 1'b1;
                e_byte   = r_rdata;
            end
            S_CR: begin
                emit_req = 1'b1;
                e_byte   = CH_CR;
            end
            S_LF: begin
                emit_req = 1'b1;
                e_byte   = CH_LF;
            end
            S_NEM: begin
                emit_req = 1'b1;
                e_kind   = KIND_LINE;
                e_byte   = r_rdata;
            end
            S_NEND: begin
                emit_req = 1'b1;
                e_kind   = KIND_END;
            end
            S_FIN: begin
                fin = 1'b1;
            end
            default: begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_ok   = !r_pend_valid || out_free;
    assign do_emit   = emit_req && emit_ok;
    assign fin_load  = fin && r_pend_valid && out_free;
    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;

    // line memory: one write and one registered read per cycle
    // delete reads one place above the slot it writes, also while it waits
    assign mem_we    = do_emit && (r_state == S_IEM || r_state == S_DEM);
    assign mem_wdata = (r_state == S_IEM) ? r_carry : r_rdata;
    assign rd_idx    = (r_state == S_DRD || r_state == S_DEM) ? r_idx + 1'b1 : r_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_mem[r_idx[ADDR_W-1:0]] <= mem_wdata;
        end
        r_rdata <= r_line_mem[rd_idx[ADDR_W-1:0]];
    end

    // sequencer, hold stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur        <= '0;
            r_len        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // hold stage: the held result is known to be last only at the end
            if (do_emit) begin
                r_pend_valid <= 1'b1;
                r_pend_kind  <= e_kind;
                r_pend_byte  <= e_byte;
            end else if (fin_load) begin
                r_pend_valid <= 1'b0;
            end
            if ((do_emit && r_pend_valid) || fin_load) begin
                r_out_valid <= 1'b1;
                r_kind      <= r_pend_kind;
                r_byte      <= r_pend_byte;
                r_last      <= fin;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= i_cmd.prompt ? S_PRM0 : S_DISP;
                    end
                end
                S_PRM0: begin
                    if (emit_ok) r_state <= S_PRM1;
                end
                S_PRM1: begin
                    if (emit_ok) r_state <= S_DISP;
                end
                S_DISP: begin
                    case (r_cmd.op)
                        OP_INS: begin
                            if (r_len >= CNT_W'(LINE_DEPTH)) begin
                                r_state <= S_FIN;
                            end else begin
                                r_idx   <= r_cur;
                                r_carry <= r_cmd.data;
                                r_state <= S_IRD;
                            end
                        end
                        OP_DEL: begin
                            if (r_cur == '0) begin
                                r_state <= S_FIN;
                            end else begin
                                r_cur   <= r_cur - 1'b1;
                                r_len   <= r_len - 1'b1;
                                r_idx   <= r_cur - 1'b1;
                                r_state <= S_DBS;
                            end
                        end
                        OP_NL: begin
                            r_state <= S_CR;
                        end
                        OP_RIGHT: begin
                            if (r_cur < r_len) begin
                                r_idx   <= r_cur;
                                r_state <= S_RRD;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                        OP_LEFT: begin
                            r_state <= (r_cur != '0) ? S_LFT : S_FIN;
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                // insert: walk up from the cursor, writing the carried byte
                S_IRD: begin
                    r_state <= S_IEM;
                end
                S_IEM: begin
                    if (emit_ok) begin
                        r_carry <= r_rdata;
                        if (r_idx == r_len) begin
                            r_len   <= r_len + 1'b1;
                            r_cur   <= r_cur + 1'b1;
                            r_cnt   <= r_len - r_cur;
                            r_state <= S_BS;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_IRD;
                        end
                    end
                end
                // cursor return backspaces
                S_BS: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else if (emit_ok) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                // delete: pull the tail down one place
                S_DBS: begin
                    if (emit_ok) r_state <= S_DRD;
                end
                S_DRD: begin
                    r_state <= (r_idx >= r_len) ? S_DSP : S_DEM;
                end
                S_DEM: begin
                    if (emit_ok) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_DSP: begin
                    if (emit_ok) r_state <= S_DBS2;
                end
                S_DBS2: begin
                    if (emit_ok) begin
                        r_cnt   <= r_len - r_cur;
                        r_state <= S_BS;
                    end
                end
                // cursor moves
                S_RRD: begin
                    r_state <= S_REM;
                end
                S_REM: begin
                    if (emit_ok) begin
                        r_cur   <= r_cur + 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_LFT: begin
                    if (emit_ok) begin
                        r_cur   <= r_cur - 1'b1;
                        r_state <= S_FIN;
                    end
                end
                // end of line: CR LF, line bytes, end marker
                S_CR: begin
                    if (emit_ok) r_state <= S_LF;
                end
                S_LF: begin
                    if (emit_ok) begin
                        r_idx   <= '0;
                        r_state <= S_NRD;
                    end
                end
                S_NRD: begin
                    r_state <= (r_idx >= r_len) ? S_NEND : S_NEM;
                end
                S_NEM: begin
                    if (emit_ok) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_NRD;
                    end
                end
                S_NEND: begin
                    if (emit_ok) begin
                        r_cur   <= '0;
                        r_len   <= '0;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_pend_valid || out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_byte;
    assign o_last      = r_last;

    // a command never leaves a result behind in the hold stage
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("result left in hold stage between commands");

    // cursor stays inside the line, line inside the memory
    a_cur_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur <= r_len) && (r_len <= CNT_W'(LINE_DEPTH)))
        else $error("cursor or length out of range");

    // a result marked last is followed by an idle sequencer
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_load |=> (r_state == S_IDLE) && r_out_valid && r_last)
        else $error("last result not closing the command");

endmodule

>>> rtl/core/terminal_line_editor_unit.sv
// ----------------------------------------------------------------------------
// terminal_line_editor_unit
// Line editor for a serial console with cursor keys and backspace.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one request, either an idle
// tick (i_action low) or a received byte in i_rx_byte. Output channel:
// o_out_valid / i_out_stall carry result bytes tagged by o_kind (echo, line
// byte, end marker); o_last marks the final result of a request.
// The front decodes escape sequences and queues editing commands (two deep);
// the back edits a line memory with one registered read port and emits the
// results. A request is accepted while the queue has room.
// With the back idle, an accepted request goes through the queue, the back
// sequencer, the hold stage and the output register to its first result.
// Throughput is set by the back sequencer, one memory step or one result per
// cycle while the output does not stall. Insert and delete work grows with
// the bytes behind the cursor, end of line with the line length; a pending
// prompt adds its echo. Idle ticks with nothing to echo are not queued.
// Reset: line empty, cursor at zero, prompt pending; the line memory needs
// no clearing. A stall on the output holds the output register and the back
// sequencer; the front keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module terminal_line_editor_unit #(
    parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_action,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import tle_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    tle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    tle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    tle_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

>>> test/terminal_line_editor_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// terminal_line_editor_unit_test
// Self-checking bench for the console line editor. A short table of
// keystrokes comes first, then random typing sessions with cursor keys,
// deletes, broken escapes and line ends. Every request is run through a
// behavioural editor kept here; each result byte from the block is compared
// with the oldest one predicted. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module terminal_line_editor_unit_test;
    import tle_pkg::*;

    localparam int DEPTH          = LINE_DEPTH_DEF;
    localparam int KEYS_WANTED    = 500;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int DIR_N          = 25;

    typedef enum logic [1:0] {
        ED_DATA,
        ED_ESC,
        ED_CSI,
        ED_DONE
    } t_ed_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_res;

    // one request; typed rows carry their own results instead of the predictor's
    typedef struct packed {
        logic       act;
        logic [7:0] rx;
        logic       typed;
        logic [1:0] n_typed;
        t_res       r0;
        t_res       r1;
    } t_row;

    localparam t_res NO_RES = '{KIND_ECHO, 8'h00, 1'b0};

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_action;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic       o_last;

    // behavioural editor state
    logic [7:0] ln [DEPTH];
    int         cur;
    int         len;
    t_ed_mode   ed_mode;

    t_res resp[$];
    t_res due_out[$];
    t_row key_q[$];

    int err_count;
    int snd_calm;
    int rcv_calm;
    int rcv_wait;
    int hold_asked;
    int hold_served;
    int idle_cycles;
    int n_requests;
    int n_results;
    int n_lines;
    int n_dropped;

    // directed keystrokes: prompt, extremes, escapes, edits, line ends
    t_row dir_tab [DIR_N] = '{
        '{1'b0, 8'h00,  1'b1, 2'd2, '{KIND_ECHO, CH_GT, 1'b0}, '{KIND_ECHO, CH_SP, 1'b1}},
        '{1'b0, 8'hff,  1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_DEL, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, 8'h00,  1'b1, 2'd1, '{KIND_ECHO, 8'h00, 1'b1}, NO_RES},
        '{1'b1, 8'hff,  1'b1, 2'd1, '{KIND_ECHO, 8'hff, 1'b1}, NO_RES},
        '{1'b1, CH_LB,  1'b1, 2'd1, '{KIND_ECHO, CH_LB, 1'b1}, NO_RES},
        '{1'b1, CH_TIL, 1'b1, 2'd1, '{KIND_ECHO, CH_TIL, 1'b1}, NO_RES},
        '{1'b1, CH_ESC, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_LB,  1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_LB,  1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_LT,  1'b1, 2'd1, '{KIND_ECHO, CH_BS, 1'b1}, NO_RES},
        '{1'b1, CH_ESC, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, 8'h71,  1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_TIL, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_ESC, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_LB,  1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_DN,  1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_ESC, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_ESC, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_LB,  1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_TIL, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, 8'h51,  1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_DEL, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_CR,  1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CH_LF,  1'b0, 2'd0, NO_RES, NO_RES}
    };

    terminal_line_editor_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // wait drawn per request or result; runs of zero waits now and then
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3) calm = $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 18);
    endfunction

    function automatic void put_result(logic [1:0] kind, logic [7:0] data);
        resp.push_back('{kind, data, 1'b0});
    endfunction

    // results the editor gives for one request, left in resp
    task automatic editor_response(input logic act, input logic [7:0] rx);
        int i;
        resp.delete();
        if (ed_mode == ED_DONE) begin
            put_result(KIND_ECHO, CH_GT);
            put_result(KIND_ECHO, CH_SP);
            ed_mode = ED_DATA;
        end
        if (act) begin
            if (rx == CH_ESC) begin
                ed_mode = ED_ESC;
            end else if (rx == CH_DEL) begin
                // rub out before the cursor, redraw the tail, step back
                if (cur != 0) begin
                    cur--;
                    for (i = cur; i < len - 1; i++) ln[i] = ln[i + 1];
                    len--;
                    put_result(KIND_ECHO, CH_BS);
                    for (i = cur; i < len; i++) put_result(KIND_ECHO, ln[i]);
                    put_result(KIND_ECHO, CH_SP);
                    put_result(KIND_ECHO, CH_BS);
                    for (i = len; i > cur; i--) put_result(KIND_ECHO, CH_BS);
                end
                ed_mode = ED_DATA;
            end else if (rx == CH_CR || rx == CH_LF) begin
                put_result(KIND_ECHO, CH_CR);
                put_result(KIND_ECHO, CH_LF);
                for (i = 0; i < len; i++) put_result(KIND_LINE, ln[i]);
                put_result(KIND_END, 8'h00);
                cur     = 0;
                len     = 0;
                ed_mode = ED_DONE;
                n_lines++;
            end else if (ed_mode == ED_ESC) begin
                if (rx == CH_LB) ed_mode = ED_CSI;
                else if (rx == CH_TIL) ed_mode = ED_DATA;
            end else if (ed_mode == ED_CSI) begin
                if (rx == CH_UP || rx == CH_DN || rx == CH_TIL) begin
                    ed_mode = ED_DATA;
                end else if (rx == CH_RT) begin
                    ed_mode = ED_DATA;
                    if (cur < len) begin
                        put_result(KIND_ECHO, ln[cur]);
                        cur++;
                    end
                end else if (rx == CH_LT) begin
                    ed_mode = ED_DATA;
                    if (cur != 0) begin
                        put_result(KIND_ECHO, CH_BS);
                        cur--;
                    end
                end
            end else if (len >= DEPTH) begin
                n_dropped++;
            end else begin
                // insert, echo from the new byte on, walk back to the cursor
                for (i = len; i > cur; i--) ln[i] = ln[i - 1];
                ln[cur] = rx;
                len++;
                for (i = cur; i < len; i++) put_result(KIND_ECHO, ln[i]);
                cur++;
                for (i = len; i > cur; i--) put_result(KIND_ECHO, CH_BS);
            end
        end
        if (resp.size() > 0) resp[resp.size() - 1].last = 1'b1;
    endtask

    // present one request, hold it until taken, then book its results
    task automatic deliver(input t_row row);
        int gap;
        gap = draw_wait(snd_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= row.act;
        i_rx_byte  <= row.rx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_requests++;
        editor_response(row.act, row.rx);
        if (row.typed) begin
            if (row.n_typed >= 2'd1) due_out.push_back(row.r0);
            if (row.n_typed >= 2'd2) due_out.push_back(row.r1);
        end else begin
            foreach (resp[k]) due_out.push_back(resp[k]);
        end
    endtask

    function automatic void queue_key(logic act, logic [7:0] rx);
        key_q.push_back('{act, rx, 1'b0, 2'd0, NO_RES, NO_RES});
    endfunction

    // next random session: mostly typing and cursor keys, some noise
    task automatic plan_keys();
        logic [7:0] csi_last [8];
        int         pick;
        int         n;
        csi_last = '{CH_UP, CH_DN, CH_RT, CH_LT, CH_RT, CH_LT, CH_TIL, 8'h00};
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            queue_key(1'b1, 8'($urandom_range(8'h20, 8'h7e)));
        end else if (pick < 46) begin
            queue_key(1'b1, 8'($urandom_range(0, 255)));
        end else if (pick < 66) begin
            n = $urandom_range(0, 7);
            queue_key(1'b1, CH_ESC);
            queue_key(1'b1, CH_LB);
            queue_key(1'b1, (n == 7) ? 8'($urandom_range(0, 255)) : csi_last[n]);
        end else if (pick < 74) begin
            queue_key(1'b1, CH_DEL);
        end else if (pick < 80) begin
            queue_key(1'b0, 8'($urandom_range(0, 255)));
        end else if (pick < 84) begin
            queue_key(1'b1, $urandom_range(0, 1) ? CH_CR : CH_LF);
        end else if (pick < 90) begin
            // broken escape: stray byte after ESC or ESC [
            queue_key(1'b1, CH_ESC);
            if ($urandom_range(0, 1)) queue_key(1'b1, CH_LB);
            n = $urandom_range(0, 3);
            queue_key(1'b1, (n == 0) ? CH_DEL : (n == 1) ? CH_ESC :
                            8'($urandom_range(0, 255)));
        end else if (pick < 94) begin
            // long run of typing, can spill past a full line
            n = $urandom_range(14, 20);
            repeat (n) queue_key(1'b1, 8'($urandom_range(8'h20, 8'h7e)));
        end else begin
            // cursor well back into the line, then insert there
            repeat ($urandom_range(2, 6)) begin
                queue_key(1'b1, CH_ESC);
                queue_key(1'b1, CH_LB);
                queue_key(1'b1, CH_LT);
            end
            queue_key(1'b1, 8'($urandom_range(8'h20, 8'h7e)));
        end
    endtask

    // result side: check against the oldest booked result, draw next stall
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (due_out.size() == 0) begin
                err_count++;
                if (err_count <= 100)
                    $display("%0t: unexpected result kind %0d byte %02h last %0b",
                             $time, o_kind, o_out_byte, o_last);
            end else begin
                want = due_out.pop_front();
                if (o_kind !== want.kind || o_out_byte !== want.data ||
                    o_last !== want.last) begin
                    err_count++;
                    if (err_count <= 100)
                        $display("%0t: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                                 $time, want.kind, want.data, want.last,
                                 o_kind, o_out_byte, o_last);
                end
            end
            rcv_wait = draw_wait(rcv_calm);
        end else if (rcv_wait > 0) begin
            rcv_wait--;
        end
        if (hold_served != hold_asked) begin
            rcv_wait    = LONG_HOLD;
            hold_served = hold_asked;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= (rcv_wait > 0);
    end

    // give up when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, due_out.size());
            $display("terminal_line_editor_unit_test: FAIL");
            $finish;
        end
    end

    // main sequence
    initial begin
        int   keys_sent;
        bit   held;
        bit   paused;
        t_row row;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = 1'b0;
        i_rx_byte   = 8'h00;
        i_out_stall = 1'b0;
        err_count   = 0;
        snd_calm    = 0;
        rcv_calm    = 0;
        rcv_wait    = 0;
        hold_asked  = 0;
        hold_served = 0;
        idle_cycles = 0;
        n_requests  = 0;
        n_results   = 0;
        n_lines     = 0;
        n_dropped   = 0;
        keys_sent   = 0;
        held        = 1'b0;
        paused      = 1'b0;
        cur         = 0;
        len         = 0;
        ed_mode     = ED_DONE;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) deliver(dir_tab[r]);

        // random sessions
        while (keys_sent < KEYS_WANTED) begin
            if (!held && keys_sent >= 150) begin
                // receiver holds off while requests keep coming
                held = 1'b1;
                hold_asked++;
                snd_calm = 40;
            end
            if (!paused && keys_sent >= 320) begin
                // sender waits for the block to drain completely
                paused = 1'b1;
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (due_out.size() != 0) @(posedge i_clk);
            end
            if (key_q.size() == 0) plan_keys();
            row = key_q.pop_front();
            deliver(row);
            if (row.act) keys_sent++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests and %0d results, %0d lines finished,",
                 n_requests, n_results, n_lines);
        $display("%0d inserts dropped on a full line.", n_dropped);
        if (err_count == 0 && due_out.size() == 0) begin
            $display("terminal_line_editor_unit_test: PASS");
        end else begin
            $display("%0d mismatches, %0d results never seen", err_count, due_out.size());
            $display("terminal_line_editor_unit_test: FAIL");
        end
        $finish;
    end

endmodule
